/* rtl/core/pbd_pkg.sv */
// Shared types, constants and character tables of the PEM base64 decoder.
`default_nettype none
package pbd_pkg;

	localparam int unsigned CAP_W            = 17;
	localparam int unsigned CAPACITY_MAX     = 65536;
	localparam logic [CAP_W-1:0] CAP_RESET   = 17'd8192;
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;

	localparam logic       KIND_DATA   = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic       WORD_BEGIN  = 1'b0;
	localparam logic       WORD_END    = 1'b1;

	localparam logic [7:0] CH_HYPHEN   = 8'h2D;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_B        = 8'h42;
	localparam logic [7:0] CH_D        = 8'h44;
	localparam logic [7:0] CH_E        = 8'h45;
	localparam logic [7:0] CH_G        = 8'h47;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_N        = 8'h4E;

	localparam logic [2:0] HYPHEN_SAT  = 3'd5;
	localparam logic [2:0] LEN_BEGIN   = 3'd5;
	localparam logic [2:0] LEN_END     = 3'd3;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_SKIP,
		MODE_ENDED
	} front_mode_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic             item_kind;
		logic [7:0]       data_byte;
		logic [1:0]       status_code;
		logic [CAP_W-1:0] byte_count;
		logic             last_of_run;
	} out_item_t;

	// One classified character: held letters to release, then one symbol, then status.
	typedef struct packed {
		logic       flush_sel;
		logic [2:0] flush_len;
		logic       sym_valid;
		logic [5:0] sym;
		logic       is_last;
	} entry_t;

	function automatic logic is_b64(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == CH_PLUS || c == CH_SLASH;
	endfunction

	function automatic logic [5:0] sym_value(input logic [7:0] c);
		logic [5:0] v;
		v = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) v = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) v = 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 8'd52);
		else if (c == CH_PLUS) v = 6'd62;
		else if (c == CH_SLASH) v = 6'd63;
		return v;
	endfunction

	// Letter at a position of the marker word.
	function automatic logic [7:0] word_char(input logic sel, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		if (sel == WORD_END) begin
			case (idx)
				3'd0: ch = CH_E;
				3'd1: ch = CH_N;
				3'd2: ch = CH_D;
				default: ch = 8'h00;
			endcase
		end else begin
			case (idx)
				3'd0: ch = CH_B;
				3'd1: ch = CH_E;
				3'd2: ch = CH_G;
				3'd3: ch = CH_I;
				3'd4: ch = CH_N;
				default: ch = 8'h00;
			endcase
		end
		return ch;
	endfunction

	function automatic logic [5:0] held_symbol(input logic sel, input logic [2:0] idx);
		return sym_value(word_char(sel, idx));
	endfunction

endpackage
`default_nettype wire

/* rtl/core/pbd_chan_if.sv */
// Valid/ready channel carrying one payload item per transfer.
`default_nettype none
interface pbd_chan_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/pbd_front.sv */
// Front end: accepts characters, tracks hyphen runs and marker words, classifies.
`default_nettype none
module pbd_front import pbd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pbd_chan_if.sink    chars,
	input  wire logic   q_full,
	output logic        q_push,
	output entry_t      q_entry
);

	front_mode_t mode_q, mode_d, mode_t;
	logic [2:0]  hyph_q, hyph_d, hyph_t;
	logic        sel_q, sel_d, sel_t;
	logic [2:0]  hlen_q, hlen_d, hlen_t;

	logic        accept;
	logic [7:0]  c;
	logic        matched;
	logic [2:0]  hlen_inc;
	logic [2:0]  wlen;
	logic        take_flush;
	logic        take_sym;

	assign chars.ready = !q_full;
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.payload.text_char;
	assign hlen_inc    = 3'(hlen_q + 3'd1);
	assign wlen        = (sel_q == WORD_END) ? LEN_END : LEN_BEGIN;
	assign matched     = (hlen_q != 3'd0) && (c == word_char(sel_q, hlen_q));

	// Effect of one character on the classifier, before end-of-text handling.
	always_comb begin
		mode_t     = mode_q;
		hyph_t     = hyph_q;
		sel_t      = sel_q;
		hlen_t     = hlen_q;
		take_flush = 1'b0;
		take_sym   = 1'b0;
		unique case (mode_q)
			MODE_SKIP: begin
				if (c == CH_NEWLINE) mode_t = MODE_NORMAL;
			end
			MODE_ENDED: begin
			end
			MODE_NORMAL: begin
				if (matched) begin
					if (hlen_inc == wlen) begin
						mode_t = (sel_q == WORD_END) ? MODE_ENDED : MODE_SKIP;
						hlen_t = 3'd0;
						sel_t  = WORD_BEGIN;
						hyph_t = 3'd0;
					end else begin
						hlen_t = hlen_inc;
					end
				end else begin
					take_flush = (hlen_q != 3'd0);
					hlen_t     = 3'd0;
					sel_t      = WORD_BEGIN;
					if (c == CH_HYPHEN) begin
						if (hlen_q != 3'd0) hyph_t = 3'd1;
						else if (hyph_q < HYPHEN_SAT) hyph_t = 3'(hyph_q + 3'd1);
					end else if (hlen_q == 3'd0 && hyph_q == HYPHEN_SAT &&
							(c == CH_B || c == CH_E)) begin
						sel_t  = (c == CH_E) ? WORD_END : WORD_BEGIN;
						hlen_t = 3'd1;
					end else begin
						hyph_t   = 3'd0;
						take_sym = is_b64(c);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Next state: end of text returns everything to reset.
	always_comb begin
		mode_d = mode_q;
		hyph_d = hyph_q;
		sel_d  = sel_q;
		hlen_d = hlen_q;
		if (accept) begin
			if (chars.payload.is_last) begin
				mode_d = MODE_NORMAL;
				hyph_d = 3'd0;
				sel_d  = WORD_BEGIN;
				hlen_d = 3'd0;
			end else begin
				mode_d = mode_t;
				hyph_d = hyph_t;
				sel_d  = sel_t;
				hlen_d = hlen_t;
			end
		end
	end

	// Outputs: entry for the queue.
	always_comb begin
		q_entry.flush_sel = WORD_BEGIN;
		q_entry.flush_len = 3'd0;
		q_entry.sym_valid = take_sym;
		q_entry.sym       = sym_value(c);
		q_entry.is_last   = chars.payload.is_last;
		if (take_flush) begin
			q_entry.flush_sel = sel_q;
			q_entry.flush_len = hlen_q;
		end else if (chars.payload.is_last && mode_t == MODE_NORMAL && hlen_t != 3'd0) begin
			// text ends with letters still held: release them before the status
			q_entry.flush_sel = sel_t;
			q_entry.flush_len = hlen_t;
		end
		q_push = accept && (take_flush || take_sym || chars.payload.is_last ||
			q_entry.flush_len != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			hyph_q <= 3'd0;
			sel_q  <= WORD_BEGIN;
			hlen_q <= 3'd0;
		end else begin
			mode_q <= mode_d;
			hyph_q <= hyph_d;
			sel_q  <= sel_d;
			hlen_q <= hlen_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/pbd_queue.sv */
// Short first-in first-out queue of classified entries between front and back.
`default_nettype none
module pbd_queue import pbd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head,
	output logic        empty,
	output logic        full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t          slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (AW+1)'(DEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : AW'(wr_ptr_q + 1'b1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : AW'(rd_ptr_q + 1'b1);
			if (push && !pop)      count_q <= (AW+1)'(count_q + 1'b1);
			else if (pop && !push) count_q <= (AW+1)'(count_q - 1'b1);
		end
	end

endmodule
`default_nettype wire

/* rtl/core/pbd_back.sv */
// Back end: decodes queued symbols into bytes, checks capacity, issues status.
`default_nettype none
module pbd_back import pbd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire entry_t           head,
	input  wire logic             empty,
	input  wire logic [CAP_W-1:0] capacity,
	output logic                  pop,
	pbd_chan_if.source            results
);

	logic [11:0]      acc_q;
	logic [2:0]       pend_q;
	logic [CAP_W-1:0] bytes_q;
	logic             ovf_q;
	logic [2:0]       idx_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [CAP_W-1:0] cap_eff;
	logic [2:0]       n_sym;
	logic [2:0]       total;
	logic             sym_step;
	logic [5:0]       cur_sym;
	logic [11:0]      acc_n;
	logic [3:0]       p6;
	logic             full_byte;
	logic [2:0]       pend_n;
	logic [7:0]       byte_n;
	logic             cap_hit;
	logic [2:0]       later;
	logic             later_emit;
	logic             room_after;
	logic             out_free;
	logic             fire;
	logic             emit_byte;
	logic             emit_status;

	assign cap_eff    = ({15'd0, capacity} > 32'(CAPACITY_MAX)) ?
		CAP_W'(CAPACITY_MAX) : capacity;
	assign n_sym      = 3'(head.flush_len + {2'b00, head.sym_valid});
	assign total      = 3'(n_sym + {2'b00, head.is_last});
	assign sym_step   = (idx_q < n_sym);
	assign cur_sym    = (idx_q < head.flush_len) ? held_symbol(head.flush_sel, idx_q) : head.sym;
	assign acc_n      = {acc_q[5:0], cur_sym};
	assign p6         = {1'b0, pend_q} + 4'd6;
	assign full_byte  = (p6 >= 4'd8);
	assign pend_n     = full_byte ? 3'(p6 - 4'd8) : p6[2:0];
	assign byte_n     = 8'(acc_n >> pend_n);
	assign cap_hit    = (bytes_q >= cap_eff);
	assign later      = 3'(n_sym - idx_q - 3'd1);
	// a symbol from empty pending bits yields no byte; from any other it does
	assign later_emit = (later >= 3'd2) || (later == 3'd1 && pend_n != 3'd0);
	assign room_after = ({1'b0, bytes_q} + 18'd1) < {1'b0, cap_eff};

	assign out_free    = !out_valid_q || results.ready;
	assign fire        = !empty && out_free;
	assign emit_byte   = fire && sym_step && !ovf_q && full_byte && !cap_hit;
	assign emit_status = fire && !sym_step;
	assign pop         = fire && (3'(idx_q + 3'd1) == total);

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pend_q      <= '0;
			bytes_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				idx_q <= pop ? 3'd0 : 3'(idx_q + 3'd1);
				if (sym_step) begin
					if (!ovf_q) begin
						acc_q  <= acc_n;
						pend_q <= pend_n;
						if (full_byte) begin
							if (cap_hit) ovf_q <= 1'b1;
							else bytes_q <= CAP_W'(bytes_q + 1'b1);
						end
					end
				end else begin
					// status closes the text: start the next one clean
					acc_q   <= '0;
					pend_q  <= '0;
					bytes_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
			if (emit_byte || emit_status) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_byte) begin
			out_q.item_kind   <= KIND_DATA;
			out_q.data_byte   <= byte_n;
			out_q.status_code <= ST_OK;
			out_q.byte_count  <= '0;
			out_q.last_of_run <= !head.is_last && !(later_emit && room_after);
		end else if (emit_status) begin
			out_q.item_kind   <= KIND_STATUS;
			out_q.data_byte   <= 8'd0;
			out_q.status_code <= ovf_q ? ST_OVERFLOW :
				((bytes_q != '0) ? ST_OK : ST_EMPTY);
			out_q.byte_count  <= bytes_q;
			out_q.last_of_run <= 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/pem_base64_decoder.sv */
// Timing: a result is registered when the decode unit takes its entry; a character's
// entry is first written into the queue and then read from it by the decode unit.
// Throughput: one character per cycle while the queue is not full; an entry holds the decode
// unit for each released marker letter, for its own symbol and for a status item, and the
// queue, four entries by default, absorbs the burst, stalling input only when full.
// Reset: arst_n clears all decode state and sets capacity_q to 8192.
`default_nettype none
module pem_base64_decoder import pbd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pbd_chan_if.sink   chars,
	pbd_chan_if.sink   cfg,
	pbd_chan_if.source results
);

	logic [CAP_W-1:0] capacity_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	entry_t           q_entry;
	entry_t           q_head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= CAP_RESET;
		else if (cfg.valid && cfg.ready) capacity_q <= CAP_W'(cfg.payload);
	end

	pbd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	pbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	pbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.capacity (capacity_q),
		.pop      (q_pop),
		.results  (results)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("entry pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("entry popped from empty queue");

	a_data_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.payload.item_kind == KIND_DATA) |->
		(results.payload.status_code == ST_OK && results.payload.byte_count == '0))
		else $error("data item carries status fields");
`endif

endmodule
`default_nettype wire

/* tb/pem_base64_decoder_tb.sv */
// Testbench of the PEM base64 decoder: random PEM-like texts checked against a scoreboard.
`default_nettype none
module pem_base64_decoder_tb;
	import pbd_pkg::*;

	localparam int RANDOM_ITEMS = 150;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT  = 1000;

	typedef enum logic [1:0] {
		DEC_NORMAL,
		DEC_SKIPLINE,
		DEC_ENDED,
		DEC_OVERFLOW
	} dec_mode_t;

	class pbd_scoreboard;
		logic [CAP_W-1:0] capacity;
		logic [11:0]      bit_acc;
		int unsigned      bits_held;
		int unsigned      decoded;
		int unsigned      hyphens;
		logic             word_sel;
		int unsigned      prefix_len;
		dec_mode_t        mode;
		out_item_t        expected_q[$];
		int unsigned      step_results;
		int               errors;

		function new();
			capacity = CAP_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			bit_acc = '0;
			bits_held = 0;
			decoded = 0;
			hyphens = 0;
			word_sel = WORD_BEGIN;
			prefix_len = 0;
			mode = DEC_NORMAL;
		endfunction

		function logic [7:0] marker_letter(logic sel, int unsigned idx);
			string w;
			w = (sel == WORD_END) ? "END" : "BEGIN";
			return w[idx];
		endfunction

		function int symbol_of(logic [7:0] c);
			if (c >= "A" && c <= "Z") return int'(c) - int'("A");
			if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
			if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
			if (c == CH_PLUS) return 62;
			if (c == CH_SLASH) return 63;
			return -1;
		endfunction

		function void push(logic kind, logic [7:0] data, logic [1:0] code, int unsigned count);
			out_item_t r;
			r.item_kind = kind;
			r.data_byte = data;
			r.status_code = code;
			r.byte_count = CAP_W'(count);
			r.last_of_run = 1'b0;
			expected_q.push_back(r);
			step_results++;
		endfunction

		function void take_symbol(logic [7:0] c);
			int v;
			int unsigned cap;
			if (mode != DEC_NORMAL) return;
			v = symbol_of(c);
			if (v < 0) return;
			bit_acc = {bit_acc[5:0], 6'(v)};
			bits_held += 6;
			if (bits_held >= 8) begin
				bits_held -= 8;
				cap = (capacity > CAPACITY_MAX) ? CAPACITY_MAX : int'(capacity);
				if (decoded >= cap) begin
					mode = DEC_OVERFLOW;
					return;
				end
				push(KIND_DATA, 8'(bit_acc >> bits_held), ST_OK, 0);
				decoded++;
			end
		endfunction

		// Decode the held marker letters as ordinary symbols.
		function void release_held();
			int unsigned i;
			for (i = 0; i < prefix_len; i++) take_symbol(marker_letter(word_sel, i));
			prefix_len = 0;
			word_sel = WORD_BEGIN;
			hyphens = 0;
		endfunction

		function void advance(logic [7:0] c);
			int unsigned wlen;
			if (mode == DEC_SKIPLINE) begin
				if (c == CH_NEWLINE) mode = DEC_NORMAL;
				return;
			end
			if (mode != DEC_NORMAL) return;
			if (prefix_len > 0) begin
				wlen = (word_sel == WORD_END) ? LEN_END : LEN_BEGIN;
				if (prefix_len < wlen && c == marker_letter(word_sel, prefix_len)) begin
					prefix_len++;
					if (prefix_len == wlen) begin
						mode = (word_sel == WORD_END) ? DEC_ENDED : DEC_SKIPLINE;
						prefix_len = 0;
						word_sel = WORD_BEGIN;
						hyphens = 0;
					end
					return;
				end
				release_held();
				if (mode != DEC_NORMAL) return;
			end
			if (c == CH_HYPHEN) begin
				if (hyphens < HYPHEN_SAT) hyphens++;
				return;
			end
			if (hyphens >= HYPHEN_SAT && (c == CH_B || c == CH_E)) begin
				word_sel = (c == CH_E) ? WORD_END : WORD_BEGIN;
				prefix_len = 1;
				return;
			end
			hyphens = 0;
			take_symbol(c);
		endfunction

		function void note_char(in_item_t it);
			logic [1:0] code;
			out_item_t  tail;
			step_results = 0;
			advance(it.text_char);
			if (it.is_last) begin
				if (mode == DEC_NORMAL && prefix_len > 0) release_held();
				if (mode == DEC_OVERFLOW) code = ST_OVERFLOW;
				else code = (decoded > 0) ? ST_OK : ST_EMPTY;
				push(KIND_STATUS, 8'h00, code, decoded);
				clear();
			end
			// mark the final result of this character
			if (step_results > 0) begin
				tail = expected_q.pop_back();
				tail.last_of_run = 1'b1;
				expected_q.push_back(tail);
			end
		endfunction

		function void compare_field(string name, logic [CAP_W-1:0] want, logic [CAP_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display({"%0t: unexpected result expected none actual",
					" kind %0d byte %0h code %0d count %0d"},
					$time, got.item_kind, got.data_byte, got.status_code, got.byte_count);
				return;
			end
			want = expected_q.pop_front();
			compare_field("item_kind", CAP_W'(want.item_kind), CAP_W'(got.item_kind));
			compare_field("data_byte", CAP_W'(want.data_byte), CAP_W'(got.data_byte));
			compare_field("status_code", CAP_W'(want.status_code), CAP_W'(got.status_code));
			compare_field("byte_count", want.byte_count, got.byte_count);
			compare_field("last_of_run", CAP_W'(want.last_of_run), CAP_W'(got.last_of_run));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pbd_chan_if #(.payload_t(in_item_t))         chars_if ();
	pbd_chan_if #(.payload_t(logic [CAP_W-1:0])) cfg_if ();
	pbd_chan_if #(.payload_t(out_item_t))        res_if ();

	pem_base64_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.cfg     (cfg_if),
		.results (res_if)
	);

	pbd_scoreboard sb = new();

	logic [7:0] text_q[$];
	int         tx_idle_pct;
	int         rx_stall_pct;
	int         rand_sent;
	int         quiet = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
	end

	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (cfg_if.valid && cfg_if.ready) ||
			(res_if.valid && res_if.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] rand_b64();
		int r;
		r = $urandom_range(63);
		if (r < 26) return 8'("A" + r);
		if (r < 52) return 8'("a" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return (r == 62) ? CH_PLUS : CH_SLASH;
	endfunction

	function automatic void add_chr(logic [7:0] c);
		text_q.push_back(c);
	endfunction

	function automatic void add_str(string s);
		int i;
		for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	function automatic void add_hyphens(int n);
		repeat (n) text_q.push_back(CH_HYPHEN);
	endfunction

	task automatic send_char(in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.payload <= it;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		sb.note_char(it);
	endtask

	// Send the built text, flagging its final character.
	task automatic send_text();
		in_item_t it;
		int i;
		if (text_q.size() == 0) add_chr(CH_NEWLINE);
		for (i = 0; i < text_q.size(); i++) begin
			it.text_char = text_q[i];
			it.is_last = (i == text_q.size() - 1);
			send_char(it);
		end
		text_q.delete();
	endtask

	// Drain all results and let the block go quiet.
	task automatic settle();
		chars_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.capacity = value;
	endtask

	initial begin
		int t;
		int sel;
		int n;
		int i;
		int unsigned cut;
		string word;
		logic [CAP_W-1:0] cap;

		chars_if.valid <= 1'b0;
		chars_if.payload <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.payload <= '0;
		arst_n <= 1'b0;
		tx_idle_pct = 7;
		rx_stall_pct = 54;
		rand_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ends of the alphabet ranges, padding and a high byte at the reset capacity
		add_str("AZaz09+/=");
		add_chr(8'hFF);
		send_text();
		// text with nothing to decode
		add_chr(CH_NEWLINE);
		send_text();
		// zero capacity: first completed byte overflows
		settle();
		write_capacity('0);
		add_str("AA");
		send_text();
		// overflow while releasing held marker letters
		settle();
		write_capacity(CAP_W'(1));
		add_str("AA-----BEGIx");
		send_text();

		t = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			if (rand_sent < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 7;
				rx_stall_pct = 54;
			end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 54;
				rx_stall_pct = 7;
			end else begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			if (t % 2 == 0) begin
				case ((t / 2) % 6)
					0: cap = '1;
					1: cap = CAP_W'(1);
					2: cap = CAP_W'($urandom_range(12, 2));
					3: cap = CAP_W'(CAPACITY_MAX);
					4: cap = '0;
					default: cap = CAP_W'($urandom_range(17'h1FFFF));
				endcase
				settle();
				write_capacity(cap);
			end
			sel = $urandom_range(99);
			if (sel < 60) begin
				// armored block: header line, body, footer with trailing junk
				if ($urandom_range(3) != 0) begin
					add_hyphens($urandom_range(7, 5));
					add_str("BEGIN");
					repeat ($urandom_range(3)) add_chr($urandom_range(1) ? rand_b64() : 8'h20);
					add_hyphens($urandom_range(5));
					add_chr(CH_NEWLINE);
				end
				repeat ($urandom_range(16, 2)) begin
					n = $urandom_range(9);
					if (n == 0) add_chr(CH_NEWLINE);
					else if (n == 1) add_chr("=");
					else add_chr(rand_b64());
				end
				if ($urandom_range(3) != 0) begin
					add_hyphens($urandom_range(6, 5));
					add_str("END");
					repeat ($urandom_range(3)) add_chr(8'($urandom_range(255)));
				end
			end else if (sel < 85) begin
				// marker words cut short by a stray character
				repeat ($urandom_range(3, 1)) begin
					repeat ($urandom_range(4)) add_chr(rand_b64());
					add_hyphens($urandom_range(7, 3));
					if ($urandom_range(1)) word = "BEGIN";
					else word = "END";
					n = $urandom_range(word.len(), 1);
					for (i = 0; i < n; i++) add_chr(word[i]);
					case ($urandom_range(5))
						0: add_chr(rand_b64());
						1: add_chr(CH_HYPHEN);
						2: add_chr(CH_B);
						3: add_chr(CH_E);
						4: add_chr(CH_NEWLINE);
						default: add_chr(8'($urandom_range(255)));
					endcase
				end
			end else begin
				repeat ($urandom_range(12, 3)) add_chr(8'($urandom_range(255)));
			end
			// end some texts early, in whatever state they reached
			if ($urandom_range(4) == 0) begin
				cut = $urandom_range(text_q.size(), 1);
				while (text_q.size() > cut) void'(text_q.pop_back());
			end
			rand_sent += (text_q.size() == 0) ? 1 : text_q.size();
			send_text();
			t++;
		end

		chars_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
